FILE: sv/psp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_pkg: shared types and constants of the particle slot pool
// Request and response layouts, operation and allocation codes, and the
// default sizes handed to the top level.
// ----------------------------------------------------------------------------
package psp_pkg;

   // Default sizes of the pool and of the time fields.
   localparam int NUM_SLOTS_DEF = 1024;
   localparam int TIME_BITS_DEF = 16;

   // Fixed field widths of the request and response.
   localparam int FUNC_W  = 2;
   localparam int DT_W    = 16;
   localparam int LIFE_W  = 16;
   localparam int PICK_W  = 16;
   localparam int SLOT_OW = 10;
   localparam int KIND_W  = 2;
   localparam int COUNT_W = 11;
   localparam int CSR_W   = 11;

   // Bit counter of the remainder unit, one bit of the pick per step.
   localparam int PICK_CNT_W = $clog2(PICK_W);

   // Value of the pool limit register after reset.
   localparam logic [CSR_W-1:0] MAX_PART_RESET = 11'd1024;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // Allocation kinds reported with every response.
   localparam logic [KIND_W-1:0] KIND_REUSED  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GROWN   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RECYCLE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [DT_W-1:0]   dt;
      logic [LIFE_W-1:0] lifetime;
      logic [PICK_W-1:0] recycle_pick;
   } req_type;

   typedef struct packed {
      logic [SLOT_OW-1:0] slot;
      logic [KIND_W-1:0]  alloc_kind;
      logic [COUNT_W-1:0] alive_count;
      logic [COUNT_W-1:0] retired_count;
   } rsp_type;

endpackage

FILE: sv/particle_slot_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_slot_pool: free-list slot allocator with random eviction
// Holds age, lifetime and live flag of every particle slot in one memory and
// a LIFO stack of freed slots in a second memory. A small sequencer drives
// one shared datapath: a bit-serial remainder unit for victim selection and
// an add/compare unit that walks the slots one per cycle when ageing.
//
// Usage: a request is taken on a clock edge where start is high and busy is
// low; busy then stays high until the request is finished. Exactly one
// response is presented per request on rsp_data for one cycle, flagged by
// rsp_strobe; the receiver cannot stall it. busy falls in the cycle the
// response is shown, so the next request may be taken in that cycle.
// Steps from the accepting edge to the response cycle:
//   allocation from a free slot: stack read, slot write, reply;
//   allocation that grows the pool: slot write, reply;
//   allocation that recycles a live slot: 16 remainder steps, slot write, reply;
//   ageing tick: one slot per cycle through the slot memory's separate read
//   and write ports, then reply; clear or unknown operation: reply only.
// The pool limit is written on the csr channel, which is always ready.
// Reset empties the pool at once through the fill count; no sweep is needed.
// ----------------------------------------------------------------------------
module particle_slot_pool #(
   parameter int NUM_SLOTS = psp_pkg::NUM_SLOTS_DEF,
   parameter int TIME_BITS = psp_pkg::TIME_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  psp_pkg::req_type             req_data,
   output logic                         rsp_strobe,
   output psp_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [psp_pkg::CSR_W-1:0]    csr_wdata
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam int ENT_W  = 2 * TIME_BITS + 1;
   localparam int LIVE_B = 2 * TIME_BITS;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
   localparam logic [63:0] TIME_MAX64 = 64'(TIME_MAX);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_POP   = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_WRITE = 3'd3;
   localparam logic [2:0] ST_TICK  = 3'd4;
   localparam logic [2:0] ST_REPLY = 3'd5;

   // Control registers.
   logic [2:0]                      state_ff, state_in;
   logic [CNT_W-1:0]                free_depth_ff, free_depth_in;
   logic [CNT_W-1:0]                pool_size_ff, pool_size_in;
   logic [CNT_W-1:0]                live_total_ff, live_total_in;
   logic [CNT_W-1:0]                retired_ff, retired_in;
   logic [psp_pkg::CSR_W-1:0]       max_part_ff, max_part_in;
   logic [psp_pkg::PICK_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic                            chk_vld_ff, chk_vld_in;
   logic                            rsp_strobe_ff, rsp_strobe_in;

   // Payload registers.
   logic [SLOT_W-1:0]               slot_ff, slot_in;
   logic [psp_pkg::KIND_W-1:0]      kind_ff, kind_in;
   logic [TIME_BITS-1:0]            dt_ff, dt_in;
   logic [TIME_BITS-1:0]            life_ff, life_in;
   logic [psp_pkg::PICK_W-1:0]      pick_ff, pick_in;
   logic [CNT_W:0]                  rem_ff, rem_in;
   logic [CNT_W-1:0]                scan_ff, scan_in;
   logic [SLOT_W-1:0]               chk_idx_ff, chk_idx_in;
   psp_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   // Memories and their ports.
   logic [ENT_W-1:0]                ent_mem [NUM_SLOTS];
   logic [ENT_W-1:0]                ent_rdata_ff;
   logic [SLOT_W-1:0]               ent_raddr;
   logic                            ent_we;
   logic [SLOT_W-1:0]               ent_waddr;
   logic [ENT_W-1:0]                ent_wdata;
   logic [SLOT_W-1:0]               fs_mem [NUM_SLOTS];
   logic [SLOT_W-1:0]               fs_rdata_ff;
   logic [SLOT_W-1:0]               fs_raddr;
   logic                            fs_we;
   logic [SLOT_W-1:0]               fs_waddr;

   // Combinational helpers.
   logic                            accept;
   logic [CNT_W-1:0]                fd_m1;
   logic [31:0]                     max32, limit32;
   logic                            grow_ok;
   logic [63:0]                     dt64, life64;
   logic [TIME_BITS-1:0]            dt_sat, life_sat;
   logic [CNT_W:0]                  rem_shift, rem_next;
   logic                            ent_live;
   logic [TIME_BITS-1:0]            ent_life, ent_age;
   logic [TIME_BITS:0]              age_sum;
   logic [TIME_BITS-1:0]            age_new;
   logic                            expire;
   logic                            scan_issue;
   logic [31:0]                     slot32, live32, ret32;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign fd_m1     = free_depth_ff - CNT_W'(1);
   assign fs_raddr  = fd_m1[SLOT_W-1:0];
   assign ent_raddr = scan_ff[SLOT_W-1:0];
   assign fs_waddr  = free_depth_ff[SLOT_W-1:0];

   // Pool limit, clamped to one slot at least and to the storage size.
   always_comb begin
      max32 = 32'(max_part_ff);
      if (max32 == 32'd0) begin
         limit32 = 32'd1;
      end else if (max32 > 32'(NUM_SLOTS)) begin
         limit32 = 32'(NUM_SLOTS);
      end else begin
         limit32 = max32;
      end
      grow_ok = 32'(pool_size_ff) < limit32;
   end

   // Saturate the incoming time fields to the stored time width.
   always_comb begin
      dt64     = 64'(req_data.dt);
      life64   = 64'(req_data.lifetime);
      dt_sat   = (dt64 > TIME_MAX64) ? TIME_MAX : TIME_BITS'(dt64);
      life_sat = (life64 > TIME_MAX64) ? TIME_MAX : TIME_BITS'(life64);
   end

   // One restoring step of the pick-modulo-pool-size remainder.
   always_comb begin
      rem_shift = {rem_ff[CNT_W-1:0], pick_ff[psp_pkg::PICK_W-1]};
      if (rem_shift >= {1'b0, pool_size_ff}) begin
         rem_next = rem_shift - {1'b0, pool_size_ff};
      end else begin
         rem_next = rem_shift;
      end
   end

   // Ageing of the slot read in the previous cycle.
   always_comb begin
      ent_live = ent_rdata_ff[LIVE_B];
      ent_life = ent_rdata_ff[LIVE_B-1:TIME_BITS];
      ent_age  = ent_rdata_ff[TIME_BITS-1:0];
      age_sum  = {1'b0, ent_age} + {1'b0, dt_ff};
      age_new  = age_sum[TIME_BITS] ? TIME_MAX : age_sum[TIME_BITS-1:0];
      expire   = age_new > ent_life;
   end

   // Response fields, widened before they are cut to the response width.
   assign slot32 = 32'(slot_ff);
   assign live32 = 32'(live_total_ff);
   assign ret32  = 32'(retired_ff);

   assign scan_issue = (state_ff == ST_TICK) && (scan_ff < pool_size_ff);

   // Sequencer and datapath next state.
   always_comb begin
      state_in      = state_ff;
      free_depth_in = free_depth_ff;
      pool_size_in  = pool_size_ff;
      live_total_in = live_total_ff;
      retired_in    = retired_ff;
      max_part_in   = max_part_ff;
      bit_cnt_in    = bit_cnt_ff;
      chk_vld_in    = 1'b0;
      rsp_strobe_in = 1'b0;
      slot_in       = slot_ff;
      kind_in       = kind_ff;
      dt_in         = dt_ff;
      life_in       = life_ff;
      pick_in       = pick_ff;
      rem_in        = rem_ff;
      scan_in       = scan_ff;
      chk_idx_in    = chk_idx_ff;
      rsp_data_in   = rsp_data_ff;
      ent_we        = 1'b0;
      ent_waddr     = slot_ff;
      ent_wdata     = {1'b1, life_ff, {TIME_BITS{1'b0}}};
      fs_we         = 1'b0;

      if (csr_valid && csr_ready) begin
         max_part_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dt_in      = dt_sat;
               life_in    = life_sat;
               pick_in    = req_data.recycle_pick;
               slot_in    = '0;
               kind_in    = psp_pkg::KIND_NONE;
               retired_in = '0;
               scan_in    = '0;
               rem_in     = '0;
               bit_cnt_in = psp_pkg::PICK_CNT_W'(psp_pkg::PICK_W - 1);
               case (req_data.func)
                  psp_pkg::FUNC_ALLOC: begin
                     if (free_depth_ff != '0) begin
                        // Top of the free stack is read at this edge.
                        free_depth_in = fd_m1;
                        live_total_in = live_total_ff + CNT_W'(1);
                        kind_in       = psp_pkg::KIND_REUSED;
                        state_in      = ST_POP;
                     end else if (grow_ok) begin
                        slot_in       = pool_size_ff[SLOT_W-1:0];
                        pool_size_in  = pool_size_ff + CNT_W'(1);
                        live_total_in = live_total_ff + CNT_W'(1);
                        kind_in       = psp_pkg::KIND_GROWN;
                        state_in      = ST_WRITE;
                     end else begin
                        kind_in  = psp_pkg::KIND_RECYCLE;
                        state_in = ST_DIV;
                     end
                  end
                  psp_pkg::FUNC_TICK: begin
                     state_in = (pool_size_ff == '0) ? ST_REPLY : ST_TICK;
                  end
                  psp_pkg::FUNC_CLEAR: begin
                     free_depth_in = '0;
                     pool_size_in  = '0;
                     live_total_in = '0;
                     state_in      = ST_REPLY;
                  end
                  default: begin
                     state_in = ST_REPLY;
                  end
               endcase
            end
         end

         ST_POP: begin
            slot_in  = fs_rdata_ff;
            state_in = ST_WRITE;
         end

         ST_DIV: begin
            rem_in  = rem_next;
            pick_in = {pick_ff[psp_pkg::PICK_W-2:0], 1'b0};
            if (bit_cnt_ff == '0) begin
               slot_in  = rem_next[SLOT_W-1:0];
               state_in = ST_WRITE;
            end else begin
               bit_cnt_in = bit_cnt_ff - psp_pkg::PICK_CNT_W'(1);
            end
         end

         ST_WRITE: begin
            // Fresh slot: live, given lifetime, age zero.
            ent_we   = 1'b1;
            state_in = ST_REPLY;
         end

         ST_TICK: begin
            // Issue the read of the next slot.
            if (scan_issue) begin
               chk_vld_in = 1'b1;
               chk_idx_in = scan_ff[SLOT_W-1:0];
               scan_in    = scan_ff + CNT_W'(1);
            end else begin
               state_in = ST_REPLY;
            end
            // Age the slot read in the previous cycle and retire it if expired.
            if (chk_vld_ff && ent_live) begin
               ent_we    = 1'b1;
               ent_waddr = chk_idx_ff;
               ent_wdata = {!expire, ent_life, age_new};
               if (expire) begin
                  if (32'(free_depth_ff) < 32'(NUM_SLOTS)) begin
                     fs_we         = 1'b1;
                     free_depth_in = free_depth_ff + CNT_W'(1);
                  end
                  if (live_total_ff != '0) begin
                     live_total_in = live_total_ff - CNT_W'(1);
                  end
                  retired_in = retired_ff + CNT_W'(1);
               end
            end
         end

         ST_REPLY: begin
            rsp_data_in.slot          = slot32[psp_pkg::SLOT_OW-1:0];
            rsp_data_in.alloc_kind    = kind_ff;
            rsp_data_in.alive_count   = live32[psp_pkg::COUNT_W-1:0];
            rsp_data_in.retired_count = ret32[psp_pkg::COUNT_W-1:0];
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_depth_ff <= '0;
         pool_size_ff  <= '0;
         live_total_ff <= '0;
         retired_ff    <= '0;
         max_part_ff   <= psp_pkg::MAX_PART_RESET;
         bit_cnt_ff    <= '0;
         chk_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_depth_ff <= free_depth_in;
         pool_size_ff  <= pool_size_in;
         live_total_ff <= live_total_in;
         retired_ff    <= retired_in;
         max_part_ff   <= max_part_in;
         bit_cnt_ff    <= bit_cnt_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      kind_ff     <= kind_in;
      dt_ff       <= dt_in;
      life_ff     <= life_in;
      pick_ff     <= pick_in;
      rem_ff      <= rem_in;
      scan_ff     <= scan_in;
      chk_idx_ff  <= chk_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Slot memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      ent_rdata_ff <= ent_mem[ent_raddr];
   end

   // Free stack memory: push at the depth, registered read of the top.
   always_ff @(posedge clock) begin
      if (fs_we) begin
         fs_mem[fs_waddr] <= chk_idx_ff;
      end
      fs_rdata_ff <= fs_mem[fs_raddr];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // Every slot of the pool is either live or on the free stack.
   a_pool_balance: assert property (@(posedge clock) disable iff (reset)
      32'(free_depth_ff) + 32'(live_total_ff) == 32'(pool_size_ff))
      else $error("free depth plus live total differs from pool size");

   // Slot memory is only written inside the grown part of the pool.
   a_write_in_pool: assert property (@(posedge clock) disable iff (reset)
      ent_we |-> 32'(ent_waddr) < 32'(pool_size_ff))
      else $error("slot memory written beyond the pool");

   // A response only follows the reply step, and the block is then free.
   a_strobe_after_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_REPLY) && !busy)
      else $error("response strobe without a preceding reply step");

endmodule

FILE: sim/slot_pool_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_pool_checker: response checker for the particle slot pool
// Watches the request, response and limit channels of the pool. It keeps its
// own copy of the slot ages, lifetimes, live flags and free stack, works out
// the response owed for every request taken, and compares each response,
// field by field, with the oldest one owed.
// ----------------------------------------------------------------------------
module slot_pool_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  psp_pkg::req_type          req_data,
   input  logic                      rsp_strobe,
   input  psp_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [psp_pkg::CSR_W-1:0] csr_wdata,
   output int                        fail_count,
   output int                        replies_owed,
   output int                        replies_seen,
   output int                        recycles_seen,
   output int                        retires_seen
);

   localparam int POOL_DEPTH = psp_pkg::NUM_SLOTS_DEF;

   // Mirror of the pool state.
   logic [psp_pkg::LIFE_W-1:0]  age_mem   [POOL_DEPTH];
   logic [psp_pkg::LIFE_W-1:0]  life_mem  [POOL_DEPTH];
   logic                        live_mem  [POOL_DEPTH];
   logic [psp_pkg::SLOT_OW-1:0] free_stack [POOL_DEPTH];
   int unsigned                 free_depth;
   int unsigned                 pool_size;
   int unsigned                 live_total;
   logic [psp_pkg::CSR_W-1:0]   max_part;

   psp_pkg::rsp_type owed_replies [$];
   int               fails;
   int               seen;
   int               recycles;
   int               retires;

   // Applies one request to the mirrored pool and returns its response.
   function automatic psp_pkg::rsp_type apply_pool_op(psp_pkg::req_type r);
      psp_pkg::rsp_type res;
      int unsigned      lim;
      int unsigned      idx;
      int unsigned      retired;
      logic [16:0]      sum;
      res.slot          = '0;
      res.alloc_kind    = psp_pkg::KIND_NONE;
      res.retired_count = '0;
      retired           = 0;
      case (r.func)
         psp_pkg::FUNC_ALLOC: begin
            lim = 32'(max_part);
            if (lim < 1) lim = 1;
            if (lim > POOL_DEPTH) lim = POOL_DEPTH;
            if (free_depth > 0) begin
               free_depth--;
               idx            = 32'(free_stack[free_depth]);
               res.alloc_kind = psp_pkg::KIND_REUSED;
               live_total++;
            end else if (pool_size < lim) begin
               idx            = pool_size;
               pool_size++;
               res.alloc_kind = psp_pkg::KIND_GROWN;
               live_total++;
            end else begin
               idx            = 32'(r.recycle_pick) % pool_size;
               res.alloc_kind = psp_pkg::KIND_RECYCLE;
            end
            age_mem[idx]  = '0;
            life_mem[idx] = r.lifetime;
            live_mem[idx] = 1'b1;
            res.slot      = idx[psp_pkg::SLOT_OW-1:0];
         end
         psp_pkg::FUNC_TICK: begin
            // Age every live slot with saturation; retire in ascending order.
            for (idx = 0; idx < pool_size; idx++) begin
               if (live_mem[idx]) begin
                  sum          = {1'b0, age_mem[idx]} + {1'b0, r.dt};
                  age_mem[idx] = sum[16] ? '1 : sum[15:0];
                  if (age_mem[idx] > life_mem[idx]) begin
                     if (free_depth < POOL_DEPTH) begin
                        free_stack[free_depth] = idx[psp_pkg::SLOT_OW-1:0];
                        free_depth++;
                     end
                     live_mem[idx] = 1'b0;
                     if (live_total > 0) live_total--;
                     retired++;
                  end
               end
            end
         end
         psp_pkg::FUNC_CLEAR: begin
            for (idx = 0; idx < POOL_DEPTH; idx++) live_mem[idx] = 1'b0;
            free_depth = 0;
            pool_size  = 0;
            live_total = 0;
         end
         default: begin
            // Unknown operations leave the pool untouched.
         end
      endcase
      res.alive_count   = live_total[psp_pkg::COUNT_W-1:0];
      res.retired_count = retired[psp_pkg::COUNT_W-1:0];
      return res;
   endfunction

   // Reports one field that differs from the prediction.
   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fails++;
      end
   endtask

   // Everything is sampled at the rising edge, before the edge's updates land.
   always @(posedge clock) begin : watch
      psp_pkg::rsp_type want;
      int               i;
      if (reset) begin
         for (i = 0; i < POOL_DEPTH; i++) live_mem[i] = 1'b0;
         free_depth = 0;
         pool_size  = 0;
         live_total = 0;
         max_part   = psp_pkg::MAX_PART_RESET;
         owed_replies.delete();
         fails      = 0;
         seen       = 0;
         recycles   = 0;
         retires    = 0;
      end else begin
         // A response leaving at this edge belongs to an earlier request.
         if (rsp_strobe) begin
            if (owed_replies.size() == 0) begin
               $error("response with no request outstanding");
               fails++;
            end else begin
               want = owed_replies.pop_front();
               check_field("slot", 32'(want.slot), 32'(rsp_data.slot));
               check_field("alloc_kind", 32'(want.alloc_kind),
                           32'(rsp_data.alloc_kind));
               check_field("alive_count", 32'(want.alive_count),
                           32'(rsp_data.alive_count));
               check_field("retired_count", 32'(want.retired_count),
                           32'(rsp_data.retired_count));
               seen++;
               if (want.alloc_kind == psp_pkg::KIND_RECYCLE) recycles++;
               retires += 32'(want.retired_count);
            end
         end
         // A request taken at this edge still sees the old limit.
         if (start && !busy) owed_replies = {owed_replies, apply_pool_op(req_data)};
         if (csr_valid && csr_ready) max_part = csr_wdata;
      end
      fail_count    <= fails;
      replies_owed  <= owed_replies.size();
      replies_seen  <= seen;
      recycles_seen <= recycles;
      retires_seen  <= retires;
   end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top-level testbench of the particle slot pool
// Drives a directed opening (empty-pool ticks, saturating ages, zero and full
// lifetimes, LIFO reuse, clamped and lowered limits, clear and unknown
// operations) and then random phases under a range of pool limits, with
// random gaps between requests. The checker beside the block does the
// prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

   // Operation code the block does not define.
   localparam logic [psp_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int NUM_PHASES  = 10;
   localparam int PHASE_ITEMS = 125;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      start     = 1'b0;
   logic                      busy;
   psp_pkg::req_type          req_data  = '0;
   logic                      rsp_strobe;
   psp_pkg::rsp_type          rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [psp_pkg::CSR_W-1:0] csr_wdata = '0;

   int fail_count;
   int replies_owed;
   int replies_seen;
   int recycles_seen;
   int retires_seen;

   int n_alloc;
   int n_tick;
   int n_clear;
   int n_other;
   int n_writes;

   particle_slot_pool dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   slot_pool_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .replies_owed  (replies_owed),
      .replies_seen  (replies_seen),
      .recycles_seen (recycles_seen),
      .retires_seen  (retires_seen)
   );

   // 100 MHz clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #(60_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic psp_pkg::req_type mk(input logic [psp_pkg::FUNC_W-1:0] f,
                                           input int unsigned dt,
                                           input int unsigned life,
                                           input int unsigned pick);
      psp_pkg::req_type r;
      r.func         = f;
      r.dt           = dt[psp_pkg::DT_W-1:0];
      r.lifetime     = life[psp_pkg::LIFE_W-1:0];
      r.recycle_pick = pick[psp_pkg::PICK_W-1:0];
      return r;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Allocation-heavy mix, with lifetimes long enough for slots to build up.
   function automatic psp_pkg::req_type random_request();
      psp_pkg::req_type r;
      int unsigned      roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)      r.func = psp_pkg::FUNC_ALLOC;
      else if (roll < 90) r.func = psp_pkg::FUNC_TICK;
      else if (roll < 93) r.func = psp_pkg::FUNC_CLEAR;
      else                r.func = FUNC_UNUSED;
      case ($urandom_range(0, 3))
         0:       r.lifetime = 16'($urandom_range(0, 15));
         1:       r.lifetime = 16'($urandom_range(0, 16'h0FFF));
         2:       r.lifetime = 16'($urandom_range(0, 16'hFFFF));
         default: r.lifetime = 16'hFFFF;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 70)      r.dt = 16'($urandom_range(0, 16'h0200));
      else if (roll < 90) r.dt = 16'($urandom_range(0, 16'hFFFF));
      else if (roll < 95) r.dt = 16'hFFFF;
      else                r.dt = '0;
      r.recycle_pick = 16'($urandom_range(0, 16'hFFFF));
      return r;
   endfunction

   // Presents one request and holds it until taken; start stays high on gap 0.
   task automatic send_req(input psp_pkg::req_type r, input int gap);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      case (r.func)
         psp_pkg::FUNC_ALLOC: n_alloc++;
         psp_pkg::FUNC_TICK:  n_tick++;
         psp_pkg::FUNC_CLEAR: n_clear++;
         default:             n_other++;
      endcase
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until every owed response has come back and the block is idle.
   task automatic drain();
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while (replies_owed != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [psp_pkg::CSR_W-1:0] v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      n_writes++;
   endtask

   initial begin : stimulus
      logic [psp_pkg::CSR_W-1:0] phase_limit [NUM_PHASES];
      int  p;
      int  k;
      bit  no_idle;

      n_alloc  = 0;
      n_tick   = 0;
      n_clear  = 0;
      n_other  = 0;
      n_writes = 0;
      phase_limit = '{11'd1, 11'd0, 11'd2047, 11'd3, 11'd16, 11'd1024, 11'd64,
                      11'd2, 11'd200, 11'd9};
      phase_limit[NUM_PHASES-1] = 11'($urandom_range(0, 2047));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening at the reset limit.
      send_req(mk(psp_pkg::FUNC_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF), pick_gap());
      send_req(mk(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF), pick_gap());
      send_req(mk(psp_pkg::FUNC_ALLOC, 0, 0, 0), pick_gap());
      send_req(mk(psp_pkg::FUNC_ALLOC, 0, 16'hFFFF, 16'hFFFF), pick_gap());
      send_req(mk(psp_pkg::FUNC_ALLOC, 0, 16'h0100, 0), pick_gap());
      // A zero step leaves a zero lifetime alive; a step of one retires it.
      send_req(mk(psp_pkg::FUNC_TICK, 0, 0, 0), pick_gap());
      send_req(mk(psp_pkg::FUNC_TICK, 1, 0, 0), pick_gap());
      send_req(mk(psp_pkg::FUNC_ALLOC, 0, 16'h8000, 0), pick_gap());
      // Saturated ages retire all but the full lifetime, pushed in order.
      send_req(mk(psp_pkg::FUNC_TICK, 16'hFFFF, 0, 0), pick_gap());
      send_req(mk(psp_pkg::FUNC_ALLOC, 0, 16'h00FF, 0), pick_gap());
      send_req(mk(psp_pkg::FUNC_ALLOC, 0, 16'h00FF, 0), pick_gap());
      send_req(mk(psp_pkg::FUNC_ALLOC, 0, 16'h00FF, 0), pick_gap());
      send_req(mk(psp_pkg::FUNC_TICK, 16'hFFFF, 0, 0), pick_gap());
      send_req(mk(psp_pkg::FUNC_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF), pick_gap());
      send_req(mk(FUNC_UNUSED, 0, 0, 0), pick_gap());

      // A zero limit behaves as one: the second allocation recycles.
      drain();
      write_limit(11'd0);
      send_req(mk(psp_pkg::FUNC_ALLOC, 0, 16'h1234, 0), pick_gap());
      send_req(mk(psp_pkg::FUNC_ALLOC, 0, 16'h4321, 16'hFFFF), pick_gap());
      send_req(mk(psp_pkg::FUNC_ALLOC, 0, 16'hABCD, 0), pick_gap());
      // Above the slot count the limit is clamped; grow the pool to three.
      drain();
      write_limit(11'd2047);
      send_req(mk(psp_pkg::FUNC_ALLOC, 0, 16'h0800, 0), pick_gap());
      send_req(mk(psp_pkg::FUNC_ALLOC, 0, 16'h0800, 0), pick_gap());
      // Lowering the limit below the pool size never shrinks it.
      drain();
      write_limit(11'd1);
      send_req(mk(psp_pkg::FUNC_ALLOC, 0, 16'h0800, 16'hFFFF), pick_gap());
      send_req(mk(psp_pkg::FUNC_ALLOC, 0, 16'h0800, 16'd7), pick_gap());

      // Random phases, each under its own pool limit.
      for (p = 0; p < NUM_PHASES; p++) begin
         drain();
         write_limit(phase_limit[p]);
         no_idle = ($urandom_range(0, 3) == 0);
         for (k = 0; k < PHASE_ITEMS; k++)
            send_req(random_request(), no_idle ? 0 : pick_gap());
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Requests: %0d allocate, %0d tick, %0d clear, %0d unknown; %0d limit writes.",
               n_alloc, n_tick, n_clear, n_other, n_writes);
      $display("Responses checked: %0d, with %0d recycled slots and %0d slots retired.",
               replies_seen, recycles_seen, retires_seen);
      if (fail_count == 0 && replies_owed == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/psp_pkg.sv
sv/particle_slot_pool.sv
sim/slot_pool_checker.sv
sim/tb.sv
